// ----- hw/rtl/owtr_pkg.sv -----
package owtr_pkg;

  // Sequencer phases. Each bus reset takes four consecutive codes: poll for a
  // high line, drive low, wait for presence, recovery.
  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_WAKE_POLL = 5'd1,
    PH_WAKE_LOW  = 5'd2,
    PH_WAKE_PRES = 5'd3,
    PH_WAKE_REC  = 5'd4,
    PH_CONV_POLL = 5'd5,
    PH_CONV_LOW  = 5'd6,
    PH_CONV_PRES = 5'd7,
    PH_CONV_REC  = 5'd8,
    PH_CW_SKIP   = 5'd9,
    PH_CW_CONV   = 5'd10,
    PH_WAIT      = 5'd11,
    PH_RRST_POLL = 5'd12,
    PH_RRST_LOW  = 5'd13,
    PH_RRST_PRES = 5'd14,
    PH_RRST_REC  = 5'd15,
    PH_RW_SKIP   = 5'd16,
    PH_RW_READ   = 5'd17,
    PH_READ      = 5'd18
  } phase_t;

  typedef enum logic [1:0] {
    DRV_RELEASE = 2'd0,
    DRV_LOW     = 2'd1,
    DRV_HIGH    = 2'd2
  } drive_t;

  // Register indexes on the configuration channel.
  typedef enum logic {
    REG_CONV_WAIT = 1'b0,
    REG_RESET_LOW = 1'b1
  } reg_index_t;

  localparam logic [7:0]  CMD_SKIP       = 8'hCC;
  localparam logic [7:0]  CMD_CONVERT    = 8'h44;
  localparam logic [7:0]  CMD_READ       = 8'hBE;
  localparam logic [6:0]  POLL_LIMIT     = 7'd124;
  localparam logic [19:0] POLL_PERIOD    = 20'd2;
  localparam logic [19:0] PRESENCE_WAIT  = 20'd40;
  localparam logic [19:0] RECOVERY_TICKS = 20'd420;
  localparam logic [19:0] WR_SHORT       = 20'd5;
  localparam logic [19:0] WR_LONG        = 20'd55;
  localparam logic [19:0] WR_SLOT        = 20'd60;
  localparam logic [19:0] RD_LOW         = 20'd3;
  localparam logic [19:0] RD_SAMPLE      = 20'd12;
  localparam logic [19:0] RD_SLOT        = 20'd66;

  localparam logic [19:0] CONV_WAIT_RESET = 20'd800000;
  localparam logic [9:0]  RESET_LOW_RESET = 10'd492;

  typedef struct packed {
    drive_t             drive;
    logic               busy;
    logic               done;
    logic               present;
    logic signed [15:0] temperature;
  } result_t;

  typedef struct packed {
    phase_t      phase;
    logic [19:0] slot_timer;
    logic [6:0]  poll_count;
    logic [2:0]  bit_index;
    logic [7:0]  shift_byte;
    logic [3:0]  byte_count;
    logic [7:0]  temp_low_byte;
    logic [15:0] temp_value;
    logic        present_flag;
  } seq_state_t;

endpackage

// ----- hw/rtl/owtr_seq.sv -----
module owtr_seq #(
  parameter int NUM_PORTS     = 8,
  parameter int SCRATCH_BYTES = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  logic               func,
  input  logic [2:0]         port,
  input  logic               line_level,
  input  logic [19:0]        conv_wait,
  input  logic [9:0]         reset_low,
  output owtr_pkg::result_t  res
);

  owtr_pkg::seq_state_t st, st_next;
  logic [NUM_PORTS-1:0] ports_woken, ports_woken_next;
  logic [NUM_PORTS-1:0] port_mask;
  logic                 port_ok;
  owtr_pkg::phase_t     rst_after;
  logic                 rst_keep;

  function automatic owtr_pkg::seq_state_t enter_phase(owtr_pkg::seq_state_t s,
                                                       owtr_pkg::phase_t p);
    owtr_pkg::seq_state_t r;
    r            = s;
    r.phase      = p;
    r.slot_timer = '0;
    r.poll_count = '0;
    r.bit_index  = '0;
    r.shift_byte = '0;
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_PORTS; i++) begin
      port_mask[i] = (port == 3'(i));
    end
    port_ok = {1'b0, port} < 4'(NUM_PORTS);
  end

  // Where each of the three bus resets leads, and whether its presence
  // result is kept.
  always_comb begin
    case (st.phase)
      owtr_pkg::PH_WAKE_POLL, owtr_pkg::PH_WAKE_LOW,
      owtr_pkg::PH_WAKE_PRES, owtr_pkg::PH_WAKE_REC: begin
        rst_after = owtr_pkg::PH_CONV_POLL;
        rst_keep  = 1'b0;
      end
      owtr_pkg::PH_CONV_POLL, owtr_pkg::PH_CONV_LOW,
      owtr_pkg::PH_CONV_PRES, owtr_pkg::PH_CONV_REC: begin
        rst_after = owtr_pkg::PH_CW_SKIP;
        rst_keep  = 1'b1;
      end
      default: begin
        rst_after = owtr_pkg::PH_RW_SKIP;
        rst_keep  = 1'b0;
      end
    endcase
  end

  always_comb begin
    logic [19:0] tmr_inc;
    logic [6:0]  poll_inc;
    logic [7:0]  cmd;
    logic [7:0]  sb;
    logic [3:0]  bc_inc;

    st_next          = st;
    ports_woken_next = ports_woken;
    res.drive        = owtr_pkg::DRV_RELEASE;
    res.busy         = 1'b0;
    res.done         = 1'b0;
    tmr_inc          = st.slot_timer + 20'd1;
    poll_inc         = st.poll_count + 7'd1;
    bc_inc           = st.byte_count + 4'd1;
    sb               = st.shift_byte;
    case (st.phase)
      owtr_pkg::PH_CW_CONV: cmd = owtr_pkg::CMD_CONVERT;
      owtr_pkg::PH_RW_READ: cmd = owtr_pkg::CMD_READ;
      default:              cmd = owtr_pkg::CMD_SKIP;
    endcase

    if (func) begin
      if (st.phase == owtr_pkg::PH_IDLE && port_ok) begin
        if (|(ports_woken & port_mask)) begin
          st_next = enter_phase(st, owtr_pkg::PH_CONV_POLL);
        end else begin
          ports_woken_next = ports_woken | port_mask;
          st_next          = enter_phase(st, owtr_pkg::PH_WAKE_POLL);
        end
      end
      res.busy = (st_next.phase != owtr_pkg::PH_IDLE);
    end else if (st.phase != owtr_pkg::PH_IDLE) begin
      res.busy = 1'b1;
      case (st.phase)
        owtr_pkg::PH_WAKE_POLL, owtr_pkg::PH_CONV_POLL, owtr_pkg::PH_RRST_POLL: begin
          st_next.slot_timer = tmr_inc;
          if (tmr_inc >= owtr_pkg::POLL_PERIOD) begin
            st_next.slot_timer = '0;
            if (line_level) begin
              st_next.phase = owtr_pkg::phase_t'(5'(st.phase) + 5'd1);
            end else begin
              st_next.poll_count = poll_inc;
              if (poll_inc >= owtr_pkg::POLL_LIMIT) begin
                // The line never came up: the reset fails without presence.
                if (rst_keep) st_next.present_flag = 1'b0;
                st_next = enter_phase(st_next, rst_after);
              end
            end
          end
        end
        owtr_pkg::PH_WAKE_LOW, owtr_pkg::PH_CONV_LOW, owtr_pkg::PH_RRST_LOW: begin
          res.drive          = owtr_pkg::DRV_LOW;
          st_next.slot_timer = tmr_inc;
          if (tmr_inc >= {10'd0, reset_low}) begin
            st_next.phase      = owtr_pkg::phase_t'(5'(st.phase) + 5'd1);
            st_next.slot_timer = '0;
          end
        end
        owtr_pkg::PH_WAKE_PRES, owtr_pkg::PH_CONV_PRES, owtr_pkg::PH_RRST_PRES: begin
          st_next.slot_timer = tmr_inc;
          if (tmr_inc >= owtr_pkg::PRESENCE_WAIT) begin
            if (rst_keep) st_next.present_flag = !line_level;
            st_next.phase      = owtr_pkg::phase_t'(5'(st.phase) + 5'd1);
            st_next.slot_timer = '0;
          end
        end
        owtr_pkg::PH_WAKE_REC, owtr_pkg::PH_CONV_REC, owtr_pkg::PH_RRST_REC: begin
          st_next.slot_timer = tmr_inc;
          if (tmr_inc >= owtr_pkg::RECOVERY_TICKS) begin
            st_next = enter_phase(st_next, rst_after);
          end
        end
        owtr_pkg::PH_CW_SKIP, owtr_pkg::PH_CW_CONV,
        owtr_pkg::PH_RW_SKIP, owtr_pkg::PH_RW_READ: begin
          res.drive = (st.slot_timer < (cmd[st.bit_index] ? owtr_pkg::WR_SHORT
                                                           : owtr_pkg::WR_LONG))
                      ? owtr_pkg::DRV_LOW : owtr_pkg::DRV_HIGH;
          st_next.slot_timer = tmr_inc;
          if (tmr_inc >= owtr_pkg::WR_SLOT) begin
            st_next.slot_timer = '0;
            if (st.bit_index == 3'd7) begin
              case (st.phase)
                owtr_pkg::PH_CW_SKIP: begin
                  st_next = enter_phase(st_next, owtr_pkg::PH_CW_CONV);
                end
                owtr_pkg::PH_CW_CONV: begin
                  if (st.present_flag) begin
                    st_next = enter_phase(st_next, owtr_pkg::PH_WAIT);
                  end else begin
                    // No sensor answered: stop after the convert command.
                    st_next  = enter_phase(st_next, owtr_pkg::PH_IDLE);
                    res.done = 1'b1;
                  end
                end
                owtr_pkg::PH_RW_SKIP: begin
                  st_next = enter_phase(st_next, owtr_pkg::PH_RW_READ);
                end
                default: begin
                  st_next            = enter_phase(st_next, owtr_pkg::PH_READ);
                  st_next.byte_count = '0;
                end
              endcase
            end else begin
              st_next.bit_index = st.bit_index + 3'd1;
            end
          end
        end
        owtr_pkg::PH_WAIT: begin
          res.drive          = owtr_pkg::DRV_HIGH;
          st_next.slot_timer = tmr_inc;
          if (tmr_inc >= conv_wait) begin
            st_next = enter_phase(st_next, owtr_pkg::PH_RRST_POLL);
          end
        end
        owtr_pkg::PH_READ: begin
          res.drive = (st.slot_timer < owtr_pkg::RD_LOW) ? owtr_pkg::DRV_LOW
                                                         : owtr_pkg::DRV_RELEASE;
          if (st.slot_timer == owtr_pkg::RD_SAMPLE && line_level) begin
            sb[st.bit_index] = 1'b1;
          end
          st_next.shift_byte = sb;
          st_next.slot_timer = tmr_inc;
          if (tmr_inc >= owtr_pkg::RD_SLOT) begin
            st_next.slot_timer = '0;
            if (st.bit_index == 3'd7) begin
              if (st.byte_count == 4'd0) begin
                st_next.temp_low_byte = sb;
              end else if (st.byte_count == 4'd1) begin
                st_next.temp_value = {sb, st.temp_low_byte};
              end
              st_next.byte_count = bc_inc;
              st_next.bit_index  = '0;
              st_next.shift_byte = '0;
              if (bc_inc >= 4'(SCRATCH_BYTES)) begin
                st_next            = enter_phase(st_next, owtr_pkg::PH_IDLE);
                st_next.byte_count = '0;
                res.done           = 1'b1;
              end
            end else begin
              st_next.bit_index = st.bit_index + 3'd1;
            end
          end
        end
        default: begin
          st_next = enter_phase(st, owtr_pkg::PH_IDLE);
        end
      endcase
    end
    res.present     = st_next.present_flag;
    res.temperature = st_next.temp_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= '{phase: owtr_pkg::PH_IDLE, default: '0};
      ports_woken <= '0;
    end else if (step_en) begin
      st          <= st_next;
      ports_woken <= ports_woken_next;
    end
  end

endmodule

// ----- hw/rtl/one_wire_temperature_reader_unit.sv -----
// One-wire bus master for a single-drop temperature sensor using skip-ROM
// addressing. Each input transfer is either a one-microsecond bus tick
// (s_tuser = 0) carrying the sampled line level, or a start request
// (s_tuser = 1) naming a port; every input transfer yields exactly one
// output transfer with the drive to apply for that tick, busy/done status,
// the presence result and the last raw temperature in sixteenths of a
// degree. The first start on a port sends an extra wake-up reset. The
// block takes one transfer per clock cycle unless the output stalls, and
// passes it through the input register, then through the sequencer step
// into the output register. Configuration writes are taken at any
// time but must only be issued while no transfer is in flight; they may
// fall between the ticks of a running sequence.
module one_wire_temperature_reader_unit #(
  parameter int NUM_PORTS     = 8,
  parameter int SCRATCH_BYTES = 9
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [2:0] port, [3] line_level, [7:4] zero
  input  logic        s_tuser,    // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [1:0] line_drive, [2] busy_res, [3] present,
                                  // [19:4] temperature, [23:20] zero
  output logic        m_tlast,    // done_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);

  logic              in_valid;
  logic              in_func;
  logic [2:0]        in_port;
  logic              in_level;
  logic              advance;
  logic [19:0]       conversion_wait_us;
  logic [9:0]        reset_low_us;
  owtr_pkg::result_t step_res;
  owtr_pkg::result_t out_res;

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      conversion_wait_us <= owtr_pkg::CONV_WAIT_RESET;
      reset_low_us       <= owtr_pkg::RESET_LOW_RESET;
    end else if (cfg_valid) begin
      case (owtr_pkg::reg_index_t'(cfg_index))
        owtr_pkg::REG_CONV_WAIT: conversion_wait_us <= cfg_data;
        owtr_pkg::REG_RESET_LOW: reset_low_us       <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func  <= s_tuser;
      in_port  <= s_tdata[2:0];
      in_level <= s_tdata[3];
    end
  end

  owtr_seq #(
    .NUM_PORTS     (NUM_PORTS),
    .SCRATCH_BYTES (SCRATCH_BYTES)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .step_en    (advance),
    .func       (in_func),
    .port       (in_port),
    .line_level (in_level),
    .conv_wait  (conversion_wait_us),
    .reset_low  (reset_low_us),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tdata = {4'd0, out_res.temperature, out_res.present, out_res.busy,
                    out_res.drive};
  assign m_tlast = out_res.done;

  // A sequence can only end while it is running.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[2])
    else $error("done reported without busy");

  // The master never drives the line while idle.
  a_idle_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[1:0] == 2'd0)
    else $error("line driven while idle");

  a_drive_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("illegal line drive code");

  // A result appears only after an item has been advanced through the step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(in_valid))
    else $error("result without a stepped item");

endmodule

// ----- test/one_wire_temperature_reader_unit_tb.sv -----
`timescale 1ns / 1ps

module one_wire_temperature_reader_unit_tb;

  localparam int NUM_PORTS     = 8;
  localparam int SCRATCH_BYTES = 9;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int MAX_REPORTS   = 50;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [2:0] port, [3] line_level, [7:4] zero
  logic        s_tuser;    // [0] func
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;    // [1:0] line_drive, [2] busy_res, [3] present,
                           // [19:4] temperature, [23:20] zero
  logic        m_tlast;    // done_res
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [19:0] cfg_data;

  one_wire_temperature_reader_unit #(
    .NUM_PORTS(NUM_PORTS),
    .SCRATCH_BYTES(SCRATCH_BYTES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Bus master state as the testbench expects it to be.
  logic [19:0]       conv_wait;
  logic [9:0]        reset_low;
  owtr_pkg::phase_t  bus_phase;
  logic [19:0]       slot_cnt;
  logic [6:0]        poll_cnt;
  logic [2:0]        bit_pos;
  logic [7:0]        rx_byte;
  logic [3:0]        byte_num;
  logic [7:0]        low_byte;
  logic [15:0]       temp_word;
  logic              present_flag;
  logic [7:0]        woken_ports;

  owtr_pkg::result_t predicted_outputs[$];

  // Behavior of the simulated sensor and bus.
  bit          sensor_here;
  bit [2:0]    stuck_polls;  // [0] wake reset, [1] convert reset, [2] read reset
  logic [71:0] scratch_img;

  bit steady_flow;
  bit hold_off_req;

  int errors;
  int quiet_cycles;
  int items_sent;
  int runs;
  int absent_ends;
  int stray_starts;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void enter_phase(owtr_pkg::phase_t p);
    bus_phase = p;
    slot_cnt  = '0;
    poll_cnt  = '0;
    bit_pos   = '0;
    rx_byte   = '0;
  endfunction

  // One microsecond of bus time while a sequence runs.
  function automatic owtr_pkg::drive_t bus_tick(bit lvl, output bit fin);
    owtr_pkg::phase_t base;
    owtr_pkg::phase_t nxt;
    int               sub;
    bit               keep;
    logic [7:0]       cmd;
    owtr_pkg::drive_t drv;
    drv = owtr_pkg::DRV_RELEASE;
    fin = 1'b0;
    if ((bus_phase >= owtr_pkg::PH_WAKE_POLL && bus_phase <= owtr_pkg::PH_CONV_REC) ||
        (bus_phase >= owtr_pkg::PH_RRST_POLL && bus_phase <= owtr_pkg::PH_RRST_REC)) begin
      base = (bus_phase >= owtr_pkg::PH_RRST_POLL) ? owtr_pkg::PH_RRST_POLL :
             (bus_phase >= owtr_pkg::PH_CONV_POLL) ? owtr_pkg::PH_CONV_POLL :
                                                     owtr_pkg::PH_WAKE_POLL;
      nxt  = (base == owtr_pkg::PH_WAKE_POLL) ? owtr_pkg::PH_CONV_POLL :
             (base == owtr_pkg::PH_CONV_POLL) ? owtr_pkg::PH_CW_SKIP :
                                                owtr_pkg::PH_RW_SKIP;
      sub  = int'(bus_phase) - int'(base);
      keep = (base == owtr_pkg::PH_CONV_POLL);
      slot_cnt = slot_cnt + 20'd1;
      case (sub)
        0: begin
          if (slot_cnt >= owtr_pkg::POLL_PERIOD) begin
            slot_cnt = '0;
            if (lvl) begin
              bus_phase = owtr_pkg::phase_t'(int'(base) + 1);
            end else begin
              poll_cnt = poll_cnt + 7'd1;
              // A line that never comes up ends the reset without presence.
              if (poll_cnt >= owtr_pkg::POLL_LIMIT) begin
                if (keep) present_flag = 1'b0;
                enter_phase(nxt);
              end
            end
          end
        end
        1: begin
          drv = owtr_pkg::DRV_LOW;
          if (slot_cnt >= {10'd0, reset_low}) begin
            bus_phase = owtr_pkg::phase_t'(int'(base) + 2);
            slot_cnt  = '0;
          end
        end
        2: begin
          if (slot_cnt >= owtr_pkg::PRESENCE_WAIT) begin
            if (keep) present_flag = !lvl;
            bus_phase = owtr_pkg::phase_t'(int'(base) + 3);
            slot_cnt  = '0;
          end
        end
        default: begin
          if (slot_cnt >= owtr_pkg::RECOVERY_TICKS) enter_phase(nxt);
        end
      endcase
    end else if (bus_phase == owtr_pkg::PH_CW_SKIP || bus_phase == owtr_pkg::PH_CW_CONV ||
                 bus_phase == owtr_pkg::PH_RW_SKIP || bus_phase == owtr_pkg::PH_RW_READ) begin
      cmd = (bus_phase == owtr_pkg::PH_CW_CONV) ? owtr_pkg::CMD_CONVERT :
            (bus_phase == owtr_pkg::PH_RW_READ) ? owtr_pkg::CMD_READ : owtr_pkg::CMD_SKIP;
      drv = (slot_cnt < (cmd[bit_pos] ? owtr_pkg::WR_SHORT : owtr_pkg::WR_LONG))
            ? owtr_pkg::DRV_LOW : owtr_pkg::DRV_HIGH;
      slot_cnt = slot_cnt + 20'd1;
      if (slot_cnt >= owtr_pkg::WR_SLOT) begin
        slot_cnt = '0;
        if (bit_pos == 3'd7) begin
          case (bus_phase)
            owtr_pkg::PH_CW_SKIP: enter_phase(owtr_pkg::PH_CW_CONV);
            owtr_pkg::PH_CW_CONV: begin
              if (present_flag) begin
                enter_phase(owtr_pkg::PH_WAIT);
              end else begin
                enter_phase(owtr_pkg::PH_IDLE);
                fin = 1'b1;
                absent_ends++;
              end
            end
            owtr_pkg::PH_RW_SKIP: enter_phase(owtr_pkg::PH_RW_READ);
            default: begin
              enter_phase(owtr_pkg::PH_READ);
              byte_num = '0;
            end
          endcase
        end else begin
          bit_pos = bit_pos + 3'd1;
        end
      end
    end else if (bus_phase == owtr_pkg::PH_WAIT) begin
      drv = owtr_pkg::DRV_HIGH;
      slot_cnt = slot_cnt + 20'd1;
      if (slot_cnt >= conv_wait) enter_phase(owtr_pkg::PH_RRST_POLL);
    end else if (bus_phase == owtr_pkg::PH_READ) begin
      drv = (slot_cnt < owtr_pkg::RD_LOW) ? owtr_pkg::DRV_LOW : owtr_pkg::DRV_RELEASE;
      if (slot_cnt == owtr_pkg::RD_SAMPLE && lvl) rx_byte[bit_pos] = 1'b1;
      slot_cnt = slot_cnt + 20'd1;
      if (slot_cnt >= owtr_pkg::RD_SLOT) begin
        slot_cnt = '0;
        if (bit_pos == 3'd7) begin
          if (byte_num == 4'd0) low_byte = rx_byte;
          else if (byte_num == 4'd1) temp_word = {rx_byte, low_byte};
          byte_num = byte_num + 4'd1;
          bit_pos  = '0;
          rx_byte  = '0;
          if (byte_num >= SCRATCH_BYTES) begin
            enter_phase(owtr_pkg::PH_IDLE);
            byte_num = '0;
            fin = 1'b1;
          end
        end else begin
          bit_pos = bit_pos + 3'd1;
        end
      end
    end else begin
      enter_phase(owtr_pkg::PH_IDLE);
    end
    return drv;
  endfunction

  function automatic owtr_pkg::result_t step_bus_master(bit func, logic [2:0] port,
                                                        bit lvl);
    owtr_pkg::result_t r;
    bit                fin;
    bit                was_busy;
    r = '0;
    fin = 1'b0;
    r.drive = owtr_pkg::DRV_RELEASE;
    was_busy = (bus_phase != owtr_pkg::PH_IDLE);
    if (func) begin
      if (!was_busy && port < NUM_PORTS) begin
        if (woken_ports[port]) begin
          enter_phase(owtr_pkg::PH_CONV_POLL);
        end else begin
          woken_ports[port] = 1'b1;
          enter_phase(owtr_pkg::PH_WAKE_POLL);
        end
      end else begin
        stray_starts++;
      end
      r.busy = (bus_phase != owtr_pkg::PH_IDLE);
    end else begin
      r.busy = was_busy;
      if (was_busy) r.drive = bus_tick(lvl, fin);
    end
    r.done        = fin;
    r.present     = present_flag;
    r.temperature = temp_word;
    return r;
  endfunction

  // Line level the sensor side shows during the next tick.
  function automatic bit sensor_level();
    bit lvl;
    case (bus_phase)
      owtr_pkg::PH_WAKE_POLL: lvl = stuck_polls[0] ? 1'b0 : ($urandom_range(99) < 85);
      owtr_pkg::PH_CONV_POLL: lvl = stuck_polls[1] ? 1'b0 : ($urandom_range(99) < 85);
      owtr_pkg::PH_RRST_POLL: lvl = stuck_polls[2] ? 1'b0 : ($urandom_range(99) < 85);
      owtr_pkg::PH_WAKE_PRES, owtr_pkg::PH_CONV_PRES, owtr_pkg::PH_RRST_PRES:
        lvl = !sensor_here;
      owtr_pkg::PH_READ: begin
        if (slot_cnt == owtr_pkg::RD_SAMPLE)
          lvl = scratch_img[int'(byte_num) * 8 + int'(bit_pos)];
        else
          lvl = 1'($urandom_range(1));
      end
      default: lvl = 1'($urandom_range(1));
    endcase
    return lvl;
  endfunction

  task automatic send_item(bit func, logic [2:0] port, bit lvl);
    while (!steady_flow && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {4'b0000, lvl, port};
    do @(posedge clk); while (!s_tready);
    predicted_outputs.push_back(step_bus_master(func, port, lvl));
    items_sent++;
  endtask

  // Stops offering input and waits for every outstanding result.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (predicted_outputs.size() != 0);
  endtask

  task automatic set_timing(logic [19:0] wait_us, logic [9:0] low_us);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_index <= owtr_pkg::REG_CONV_WAIT;
    cfg_data  <= wait_us;
    do @(posedge clk); while (!cfg_ready);
    conv_wait = wait_us;
    cfg_index <= owtr_pkg::REG_RESET_LOW;
    cfg_data  <= {10'd0, low_us};
    do @(posedge clk); while (!cfg_ready);
    reset_low = low_us;
    cfg_valid <= 1'b0;
  endtask

  task automatic prepare_sensor(bit here, bit [2:0] stuck, logic [71:0] img);
    sensor_here = here;
    stuck_polls = stuck;
    scratch_img = img;
  endtask

  function automatic logic [71:0] random_scratch();
    return {8'($urandom), $urandom, $urandom};
  endfunction

  // Feeds ticks, with an occasional start request, until the sequence ends
  // or the given number of items has been sent.
  task automatic feed_ticks(int budget, int stray_pct);
    int sent;
    sent = 0;
    while (bus_phase != owtr_pkg::PH_IDLE && sent < budget) begin
      if ($urandom_range(99) < stray_pct)
        send_item(1'b1, 3'($urandom_range(7)), 1'($urandom_range(1)));
      else
        send_item(1'b0, 3'($urandom_range(7)), sensor_level());
      sent++;
    end
  endtask

  task automatic test_idle_ticks();
    for (int i = 0; i < 8; i++) send_item(1'b0, i[2:0], i[0]);
    send_item(1'b0, 3'd7, 1'b1);
    send_item(1'b0, 3'd0, 1'b0);
  endtask

  task automatic test_register_writes();
    set_timing(20'hFFFFF, 10'd1023);
    set_timing(20'd0, 10'd0);
  endtask

  task automatic test_poll_timeouts();
    // Neither the wake reset nor the convert reset sees the line come up, so
    // the sequence ends without presence right after the convert command.
    prepare_sensor(1'b1, 3'b011, random_scratch());
    runs++;
    send_item(1'b1, 3'd3, 1'b0);
    hold_off_req = 1'b1;
    feed_ticks(500, 1);
    steady_flow = 1'b1;
    feed_ticks(300, 0);
    steady_flow = 1'b0;
    feed_ticks(2000, 1);
  endtask

  task automatic test_start_on_woken_port();
    // The port is awake already, so the sequence goes straight to the convert
    // reset, here with the zero low time left by the register writes.
    prepare_sensor(1'b1, 3'b000, random_scratch());
    repeat (3) send_item(1'b0, 3'($urandom_range(7)), 1'($urandom_range(1)));
    runs++;
    send_item(1'b1, 3'd3, 1'b1);
    send_item(1'b1, 3'd5, 1'b0);
    feed_ticks(80, 0);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_outputs
    owtr_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_outputs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected transfer: expected none, got %0h", $time, m_tdata);
      end else begin
        want = predicted_outputs.pop_front();
        check_field("line_drive", 16'(want.drive), 16'(m_tdata[1:0]));
        check_field("busy_res", 16'(want.busy), 16'(m_tdata[2]));
        check_field("done_res", 16'(want.done), 16'(m_tlast));
        check_field("present", 16'(want.present), 16'(m_tdata[3]));
        check_field("temperature", want.temperature, m_tdata[19:4]);
      end
    end
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= steady_flow || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** one_wire_temperature_reader_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= owtr_pkg::REG_CONV_WAIT;
    cfg_data  <= '0;
    conv_wait = owtr_pkg::CONV_WAIT_RESET;
    reset_low = owtr_pkg::RESET_LOW_RESET;
    enter_phase(owtr_pkg::PH_IDLE);
    byte_num     = '0;
    low_byte     = '0;
    temp_word    = '0;
    present_flag = 1'b0;
    woken_ports  = '0;
    prepare_sensor(1'b1, 3'b000, '0);
    steady_flow  = 1'b0;
    hold_off_req = 1'b0;
    errors = 0;
    quiet_cycles = 0;
    items_sent = 0;
    runs = 0;
    absent_ends = 0;
    stray_starts = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_ticks();
    test_register_writes();
    test_poll_timeouts();
    test_start_on_woken_port();

    quiesce();
    repeat (8) @(posedge clk);
    $display("Sent %0d transfers: idle ticks, %0d measurement starts, %0d starts ignored.",
             items_sent, runs, stray_starts);
    $display("Covered wake and convert poll timeouts, %0d end after convert, a presence %s",
             absent_ends, "check on an awake port and a long output hold-off.");
    if (errors == 0) begin
      $display("** one_wire_temperature_reader_unit: PASSED **");
    end else begin
      $display("** one_wire_temperature_reader_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/owtr_pkg.sv
hw/rtl/owtr_seq.sv
hw/rtl/one_wire_temperature_reader_unit.sv
test/one_wire_temperature_reader_unit_tb.sv
